/* rtl/reverse_pair_counter_defines.svh */
// Assertion macros shared by the reverse pair counter RTL.
`ifndef REVERSE_PAIR_COUNTER_DEFINES_SVH
`define REVERSE_PAIR_COUNTER_DEFINES_SVH

// ante holds in a cycle -> cons holds in the same cycle
`define RPC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("reverse_pair_counter: check failed");

// ante holds in a cycle -> cons holds in the next cycle
`define RPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("reverse_pair_counter: check failed");

`endif

/* rtl/rpc_pkg.sv */
// Package: constants, opcodes and state types of the reverse pair counter.
package rpc_pkg;

   localparam int DEFAULT_VALUE_BITS = 12;
   localparam int DEFAULT_MAX_ITEMS  = 1024;
   localparam int PAIR_BITS          = 19;

   // command from the control FSM to the tree engine
   typedef enum logic [1:0] {
      OP_NONE,
      OP_QUERY,
      OP_UPDATE,
      OP_CLEAR
   } fw_op_type;

   typedef enum logic [1:0] {
      FW_IDLE,
      FW_QUERY,
      FW_UPDATE,
      FW_CLEAR
   } fw_state_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_QUERY,
      ST_QWAIT,
      ST_TALLY,
      ST_UWAIT,
      ST_FINISH
   } ctl_state_type;

endpackage

/* rtl/rpc_if.sv */
// Valid/ready channel interfaces for the sample and result transactions.
interface rpc_req_if #(
   parameter int VALUE_BITS = rpc_pkg::DEFAULT_VALUE_BITS
);
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] sample_value;
   logic                         is_last;

   modport source (output valid, output sample_value, output is_last, input ready);
   modport sink   (input valid, input sample_value, input is_last, output ready);
endinterface

interface rpc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [rpc_pkg::PAIR_BITS-1:0]  pair_count;
   logic                           overflowed;

   modport source (output valid, output pair_count, output overflowed, input ready);
   modport sink   (input valid, input pair_count, input overflowed, output ready);
endinterface

/* rtl/rpc_fenwick.sv */
// Fenwick tree engine: count memory with prefix query, point increment and clear sweep.
module rpc_fenwick #(
   parameter int VALUE_BITS = rpc_pkg::DEFAULT_VALUE_BITS,
   parameter int MAX_ITEMS  = rpc_pkg::DEFAULT_MAX_ITEMS,
   localparam int CountBits = $clog2(MAX_ITEMS + 1),
   localparam int PosBits   = VALUE_BITS + 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rpc_pkg::fw_op_type   fw_op,
   input  logic [PosBits-1:0]   fw_pos,
   output logic                 fw_idle,
   output logic [CountBits-1:0] fw_sum
);

   localparam int TreeSize = 1 << VALUE_BITS;
   localparam logic [PosBits-1:0] TreePos = PosBits'(TreeSize);

   logic [CountBits-1:0] mem [TreeSize];

   rpc_pkg::fw_state_type state_ff, state_in;
   logic [PosBits-1:0]    pos_ff, pos_in;
   logic                  pend_ff, pend_in;
   logic [VALUE_BITS-1:0] wr_addr_ff, wr_addr_in;
   logic [CountBits-1:0]  sum_ff, sum_in;
   logic [CountBits-1:0]  rd_data_ff;

   logic                  rd_en;
   logic [VALUE_BITS-1:0] rd_addr;
   logic                  wr_en;
   logic [VALUE_BITS-1:0] wr_addr;
   logic [CountBits-1:0]  wr_data;
   logic [PosBits-1:0]    low_bit;

   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      pend_in    = 1'b0;
      wr_addr_in = wr_addr_ff;
      sum_in     = sum_ff;
      rd_en      = 1'b0;
      rd_addr    = pos_ff[VALUE_BITS-1:0];
      wr_en      = 1'b0;
      wr_addr    = wr_addr_ff;
      wr_data    = rd_data_ff + CountBits'(1);
      low_bit    = pos_ff & (~pos_ff + PosBits'(1));

      case (state_ff)
         rpc_pkg::FW_IDLE: begin
            case (fw_op)
               rpc_pkg::OP_QUERY: begin
                  state_in = rpc_pkg::FW_QUERY;
                  pos_in   = fw_pos;
                  sum_in   = '0;
               end
               rpc_pkg::OP_UPDATE: begin
                  state_in = rpc_pkg::FW_UPDATE;
                  pos_in   = fw_pos;
               end
               rpc_pkg::OP_CLEAR: begin
                  state_in = rpc_pkg::FW_CLEAR;
                  pos_in   = '0;
               end
               default: ;
            endcase
         end

         // one read issued per cycle, its data accumulated in the next cycle
         rpc_pkg::FW_QUERY: begin
            sum_in = sum_ff + (pend_ff ? rd_data_ff : '0);
            if (pos_ff != '0) begin
               rd_en   = 1'b1;
               pos_in  = pos_ff - low_bit;
               pend_in = 1'b1;
            end else begin
               state_in = rpc_pkg::FW_IDLE;
            end
         end

         // pipelined read-modify-write; positions strictly increase, so the
         // write of one node never meets the read of the next
         rpc_pkg::FW_UPDATE: begin
            wr_en = pend_ff;
            if (pos_ff <= TreePos) begin
               rd_en      = 1'b1;
               wr_addr_in = pos_ff[VALUE_BITS-1:0];
               pos_in     = pos_ff + low_bit;
               pend_in    = 1'b1;
            end else begin
               state_in = rpc_pkg::FW_IDLE;
            end
         end

         rpc_pkg::FW_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff[VALUE_BITS-1:0];
            wr_data = '0;
            pos_in  = pos_ff + PosBits'(1);
            if (&pos_ff[VALUE_BITS-1:0]) begin
               state_in = rpc_pkg::FW_IDLE;
            end
         end

         default: state_in = rpc_pkg::FW_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rpc_pkg::FW_CLEAR;
         pos_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff <= wr_addr_in;
      sum_ff     <= sum_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign fw_idle = (state_ff == rpc_pkg::FW_IDLE);
   assign fw_sum  = sum_ff;

endmodule

/* rtl/reverse_pair_counter.sv */
// Reverse pair counter: per-sequence count of earlier values greater than twice the current one.
//
// req_chan carries one signed sample per transaction plus is_last; rsp_chan
// carries one result (pair_count, overflowed) for each sequence, issued when
// the sample marked is_last has been processed.
// Each sample runs a Fenwick prefix query and an increment on a count memory
// of 2^VALUE_BITS entries with a registered read port; one memory read per
// cycle sets the pace, and the next sample is taken only once the current
// one is through, sooner when the query range falls outside the stored
// values and the query is skipped. Samples past MAX_ITEMS in a sequence
// are dropped and only set overflowed.
// The result is loaded into the output register in ST_FINISH, once the
// last sample's processing ends.
// After reset, and after each sequence's last sample, the memory is swept to
// zero, one entry per cycle, with req_chan.ready low until the sweep ends.
// A stalled rsp_chan holds its result; samples keep being accepted until
// another sequence end finds the result register still full.
`include "reverse_pair_counter_defines.svh"

module reverse_pair_counter #(
   parameter int VALUE_BITS = rpc_pkg::DEFAULT_VALUE_BITS,
   parameter int MAX_ITEMS  = rpc_pkg::DEFAULT_MAX_ITEMS
) (
   input logic       clock,
   input logic       reset,
   rpc_req_if.sink   req_chan,
   rpc_rsp_if.source rsp_chan
);

   localparam int CountBits = $clog2(MAX_ITEMS + 1);
   localparam int PosBits   = VALUE_BITS + 2;
   localparam int TreeSize  = 1 << VALUE_BITS;
   localparam int PairBits  = rpc_pkg::PAIR_BITS;
   localparam logic [PosBits-1:0] HalfPos = PosBits'(TreeSize / 2);
   localparam logic [PosBits-1:0] HighPos = PosBits'(TreeSize - 1 + TreeSize / 2);
   localparam logic [PairBits-1:0] PairMax = '1;

   rpc_pkg::ctl_state_type state_ff, state_in;
   logic                   last_ff, last_in;
   logic [PosBits-1:0]     qpos_ff, qpos_in;
   logic [PosBits-1:0]     upos_ff, upos_in;
   logic [CountBits-1:0]   at_most_ff, at_most_in;
   logic [CountBits-1:0]   items_seen_ff, items_seen_in;
   logic [PairBits-1:0]    pair_total_ff, pair_total_in;
   logic                   overflow_ff, overflow_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [PairBits-1:0]    rsp_count_ff, rsp_count_in;
   logic                   rsp_ovf_ff, rsp_ovf_in;

   rpc_pkg::fw_op_type     fw_op;
   logic [PosBits-1:0]     fw_pos;
   logic                   fw_idle;
   logic [CountBits-1:0]   fw_sum;

   logic                   req_take;
   logic                   rsp_load;
   logic [VALUE_BITS-1:0]  v_off;
   logic [PosBits-1:0]     twice_off;
   logic [CountBits-1:0]   greater;
   logic [PairBits:0]      total_sum;

   rpc_fenwick #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_ITEMS  (MAX_ITEMS)
   ) u_fenwick (
      .clock   (clock),
      .reset   (reset),
      .fw_op   (fw_op),
      .fw_pos  (fw_pos),
      .fw_idle (fw_idle),
      .fw_sum  (fw_sum)
   );

   assign req_chan.ready = (state_ff == rpc_pkg::ST_IDLE) && fw_idle;
   assign req_take       = req_chan.valid && req_chan.ready;

   // value offset into 0..2^VALUE_BITS-1, and 2*value shifted by the same
   // offset plus half the range, so that negative targets stay unsigned
   assign v_off     = {~req_chan.sample_value[VALUE_BITS-1],
                       req_chan.sample_value[VALUE_BITS-2:0]};
   assign twice_off = {1'b0, v_off, 1'b0};

   assign greater   = items_seen_ff - at_most_ff;
   assign total_sum = {1'b0, pair_total_ff} + (PairBits + 1)'(greater);

   always_comb begin
      state_in      = state_ff;
      last_in       = last_ff;
      qpos_in       = qpos_ff;
      upos_in       = upos_ff;
      at_most_in    = at_most_ff;
      items_seen_in = items_seen_ff;
      pair_total_in = pair_total_ff;
      overflow_in   = overflow_ff;
      rsp_load      = 1'b0;
      fw_op         = rpc_pkg::OP_NONE;
      fw_pos        = qpos_ff;

      case (state_ff)
         rpc_pkg::ST_IDLE: begin
            if (req_take) begin
               last_in = req_chan.is_last;
               qpos_in = twice_off - HalfPos + PosBits'(1);
               upos_in = PosBits'(v_off) + PosBits'(1);
               if (items_seen_ff == CountBits'(MAX_ITEMS)) begin
                  overflow_in = 1'b1;
                  state_in    = rpc_pkg::ST_FINISH;
               end else if (twice_off < HalfPos) begin
                  at_most_in = '0;
                  state_in   = rpc_pkg::ST_TALLY;
               end else if (twice_off >= HighPos) begin
                  at_most_in = items_seen_ff;
                  state_in   = rpc_pkg::ST_TALLY;
               end else begin
                  state_in = rpc_pkg::ST_QUERY;
               end
            end
         end

         rpc_pkg::ST_QUERY: begin
            fw_op    = rpc_pkg::OP_QUERY;
            state_in = rpc_pkg::ST_QWAIT;
         end

         rpc_pkg::ST_QWAIT: begin
            if (fw_idle) begin
               at_most_in = fw_sum;
               state_in   = rpc_pkg::ST_TALLY;
            end
         end

         rpc_pkg::ST_TALLY: begin
            pair_total_in = total_sum[PairBits] ? PairMax : total_sum[PairBits-1:0];
            items_seen_in = items_seen_ff + CountBits'(1);
            fw_op         = rpc_pkg::OP_UPDATE;
            fw_pos        = upos_ff;
            state_in      = rpc_pkg::ST_UWAIT;
         end

         rpc_pkg::ST_UWAIT: begin
            if (fw_idle) begin
               state_in = rpc_pkg::ST_FINISH;
            end
         end

         rpc_pkg::ST_FINISH: begin
            if (!last_ff) begin
               state_in = rpc_pkg::ST_IDLE;
            end else if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load      = 1'b1;
               items_seen_in = '0;
               pair_total_in = '0;
               overflow_in   = 1'b0;
               fw_op         = rpc_pkg::OP_CLEAR;
               state_in      = rpc_pkg::ST_IDLE;
            end
         end

         default: state_in = rpc_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_chan.ready);
   assign rsp_count_in = rsp_load ? pair_total_ff : rsp_count_ff;
   assign rsp_ovf_in   = rsp_load ? overflow_ff : rsp_ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rpc_pkg::ST_IDLE;
         items_seen_ff <= '0;
         pair_total_ff <= '0;
         overflow_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         items_seen_ff <= items_seen_in;
         pair_total_ff <= pair_total_in;
         overflow_ff   <= overflow_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff      <= last_in;
      qpos_ff      <= qpos_in;
      upos_ff      <= upos_in;
      at_most_ff   <= at_most_in;
      rsp_count_ff <= rsp_count_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.pair_count = rsp_count_ff;
   assign rsp_chan.overflowed = rsp_ovf_ff;

   `RPC_ASSERT_IMPLY(a_items_bound, clock, reset, 1'b1, items_seen_ff <= CountBits'(MAX_ITEMS))
   `RPC_ASSERT_IMPLY(a_tally_range, clock, reset, state_ff == rpc_pkg::ST_TALLY, at_most_ff <= items_seen_ff)
   `RPC_ASSERT_NEXT(a_drop_extra, clock, reset, req_take && items_seen_ff == CountBits'(MAX_ITEMS), state_ff == rpc_pkg::ST_FINISH && overflow_ff)
   `RPC_ASSERT_NEXT(a_seq_clear, clock, reset, rsp_load, items_seen_ff == '0 && pair_total_ff == '0 && !fw_idle && rsp_valid_ff)

endmodule
